// ----- src/xtea_block_decrypt_core_macros.svh -----
// ----------------------------------------------------------------------------
// xtea block decrypt assertion macros
// clocked assertion wrappers used by the xtea output skid buffer
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_DECRYPT_CORE_MACROS_SVH
`define XTEA_BLOCK_DECRYPT_CORE_MACROS_SVH

`ifndef SYNTH
// checked on every edge outside reset
`define XTBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define XTBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XTBD_ASSERT(label, prop, msg)
`define XTBD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- src/xtbd_pkg.sv -----
// ----------------------------------------------------------------------------
// xtea block decrypt package
// beat types, round constants and register indexes of the decrypt core
// ----------------------------------------------------------------------------
package xtbd_pkg;

  localparam logic [31:0] DELTA     = 32'h9E37_79B9;
  localparam logic [31:0] NEG_DELTA = 32'h61C8_8647;

  localparam int CFG_INDEX_W = 8;
  localparam int KEY_WORDS   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY0 = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY1 = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY2 = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY3 = 8'd3;

  typedef struct packed {
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] plain_first;
    logic [31:0] plain_second;
    logic        last_out;
  } out_beat_t;

  // block halves as they travel down the chain
  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    logic        last;
  } stage_t;

endpackage

// ----- src/xtbd_cell.sv -----
// ----------------------------------------------------------------------------
// xtea half-round cell
// one registered half round: one half of the block minus the mixed other half
// ----------------------------------------------------------------------------
module xtbd_cell
  import xtbd_pkg::*;
#(
  parameter logic [31:0] SUM       = 32'h0000_0000,
  parameter bit          UPDATE_V0 = 1'b0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  stage_t      in_stage,
  input  logic [31:0] key,
  output logic        out_valid,
  output stage_t      out_stage
);

  logic [31:0] src;
  logic [31:0] mixed;
  logic [31:0] term;
  stage_t      stage_next;

  always_comb begin
    src   = UPDATE_V0 ? in_stage.v1 : in_stage.v0;
    mixed = ((src << 4) ^ (src >> 5)) + src;
    term  = mixed ^ (SUM + key);
    stage_next = in_stage;
    if (UPDATE_V0) begin
      stage_next.v0 = in_stage.v0 - term;
    end else begin
      stage_next.v1 = in_stage.v1 - term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ----- src/xtbd_skid.sv -----
// ----------------------------------------------------------------------------
// xtea output skid buffer
// two-entry result queue between the round chain and the output channel
// ----------------------------------------------------------------------------
`include "xtea_block_decrypt_core_macros.svh"

module xtbd_skid
  import xtbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_beat_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  out_beat_t   entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  cnt;
  logic [1:0]  cnt_next;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = entry[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  `XTBD_ASSERT(a_no_push_when_full, push |-> !full, "result pushed into a full skid buffer")
  `XTBD_ASSERT(a_full_holds, (full && !pop) |=> full, "skid buffer lost a result while stalled")
  `XTBD_ASSERT(a_first_result_shown, (!out_valid && push) |=> (out_valid && (out_data == $past(push_data))), "pushed result not shown at head")

endmodule

// ----- src/xtea_block_decrypt_core.sv -----
// ----------------------------------------------------------------------------
// xtea block decrypt core
// ecb xtea decryption of one 64-bit block per beat, 128-bit key
// ----------------------------------------------------------------------------
//  channel   direction  payload                                  handshake
//  in        input      cipher_first, cipher_second, last_in     in_valid / in_ready
//  out       output     plain_first, plain_second, last_out      out_valid / out_ready
//  cfg       input      key word 0..3 at cfg_index               cfg_write
//
//  one beat per cycle while out_ready keeps the skid buffer from filling; each block
//  passes through the half-round cells and then the result register of the skid buffer
//  rst is synchronous: clears all valid bits and the key words
//  when the skid buffer holds two results and the last cell holds a third, the
//  whole chain and in_ready hold until out_ready takes one
// ----------------------------------------------------------------------------
module xtea_block_decrypt_core
  import xtbd_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_beat_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int CELLS = 2 * ROUNDS;

  logic [31:0] key [KEY_WORDS];
  stage_t      stage [CELLS+1];
  logic        vld [CELLS+1];
  logic        adv;
  logic        push;
  logic        full;
  out_beat_t   push_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0;
      key[1] <= '0;
      key[2] <= '0;
      key[3] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY0: key[0] <= cfg_data;
        REG_KEY1: key[1] <= cfg_data;
        REG_KEY2: key[2] <= cfg_data;
        REG_KEY3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // chain moves unless the last cell would have nowhere to go
  assign adv      = !(vld[CELLS] && full);
  assign in_ready = adv;

  assign vld[0]        = in_valid;
  assign stage[0].v0   = in_data.cipher_first;
  assign stage[0].v1   = in_data.cipher_second;
  assign stage[0].last = in_data.last_in;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [31:0] SUM_A = DELTA * (ROUNDS - r);
    localparam logic [31:0] SUM_B = SUM_A + NEG_DELTA;

    xtbd_cell #(
      .SUM       (SUM_A),
      .UPDATE_V0 (1'b0)
    ) u_cell_v1 (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (vld[2*r]),
      .in_stage  (stage[2*r]),
      .key       (key[SUM_A[12:11]]),
      .out_valid (vld[2*r+1]),
      .out_stage (stage[2*r+1])
    );

    xtbd_cell #(
      .SUM       (SUM_B),
      .UPDATE_V0 (1'b1)
    ) u_cell_v0 (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (vld[2*r+1]),
      .in_stage  (stage[2*r+1]),
      .key       (key[SUM_B[1:0]]),
      .out_valid (vld[2*r+2]),
      .out_stage (stage[2*r+2])
    );
  end

  assign push                   = vld[CELLS] && adv;
  assign push_data.plain_first  = stage[CELLS].v0;
  assign push_data.plain_second = stage[CELLS].v1;
  assign push_data.last_out     = stage[CELLS].last;

  xtbd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
